>>> src/lpbf_pkg.sv
// Package: shared widths, constants and types for the longest-path block
`default_nettype none
package lpbf_pkg;
  localparam int MaxNodes = 256;
  localparam int MaxEdges = 1024;
  localparam int NodeW = $clog2(MaxNodes);
  localparam int EdgeW = $clog2(MaxEdges);
  localparam int CntW = EdgeW + 1;
  localparam int PassW = NodeW + 1;
  localparam int ScoreW = 48;
  localparam int WeightW = 32;
  localparam int EdgeRecW = 2 * NodeW + WeightW;
  localparam int DistRecW = ScoreW + 1;
  localparam int NodeRecW = DistRecW + 1;
  localparam int CfgW = 9;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SOURCE = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TARGET = 2'd2;

  localparam logic [1:0] ST_FINITE = 2'd0;
  localparam logic [1:0] ST_UNBOUNDED = 2'd1;
  localparam logic [1:0] ST_UNREACH = 2'd2;

  typedef struct packed {
    logic [NodeW-1:0] from;
    logic [NodeW-1:0] to;
    logic signed [WeightW-1:0] weight;
  } edge_rec_t;

  // node memory entry: reaches-target flag, distance valid, distance
  typedef struct packed {
    logic reach;
    logic valid;
    logic signed [ScoreW-1:0] score;
  } node_rec_t;
endpackage
`default_nettype wire

>>> src/lpbf_if.sv
// Interfaces: edge input channel and result output channel
`default_nettype none
interface lpbf_edge_if;
  logic valid;
  logic ready;
  logic [7:0] edge_from;
  logic [7:0] edge_to;
  logic signed [31:0] edge_weight;
  logic last_edge;
  modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
  modport sink (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

interface lpbf_result_if;
  logic valid;
  logic ready;
  logic signed [47:0] best_score;
  logic [1:0] status;
  modport source (output valid, best_score, status, input ready);
  modport sink (input valid, best_score, status, output ready);
endinterface
`default_nettype wire

>>> src/lpbf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
`default_nettype none
module lpbf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(Depth)-1:0] waddr,
  input  wire [Width-1:0]         wdata,
  input  wire [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]        rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> src/longest_path_bellman_ford.sv
// Top level: edge store, node memory and the pass sequencer
//
// channel   dir  fields                                       handshake
// edge_in   in   edge_from, edge_to, edge_weight, last_edge   valid/ready
// result    out  best_score, status                           valid/ready
// cfg       in   cfg_we, cfg_index, cfg_data                  write strobe
//
// Loading: one edge word per cycle into the edge store while idle.
// Compute: a clearing sweep over all 256 node entries, then nodes reachability passes
//   and nodes relaxation passes, each an edge read, node read and write back per stored
//   edge, then a read of the target; the passes are skipped when the source or the target
//   lies outside the nodes in use or no edge is stored.
// Reset clears control state and registers; the node memory is cleared by each sweep.
// The input stalls from the last edge until the result is loaded; a result word waits
//   in its own register and holds up the next graph only at the end of its compute.
`default_nettype none
module longest_path_bellman_ford (
  input  wire                     clk,
  input  wire                     rst,
  lpbf_edge_if.sink               edge_in,
  lpbf_result_if.source           result,
  input  wire                     cfg_we,
  input  wire [lpbf_pkg::CfgIdxW-1:0] cfg_index,
  input  wire [lpbf_pkg::CfgW-1:0]    cfg_data
);
  import lpbf_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_RD    = 7'b0000100,
    S_DRD   = 7'b0001000,
    S_WB    = 7'b0010000,
    S_TGT   = 7'b0100000,
    S_FINAL = 7'b1000000
  } state_t;

  state_t state;
  logic [CfgW-1:0] node_count;
  logic [NodeW-1:0] source_node, target_node;
  logic [CntW-1:0] edge_total;
  logic [CntW-1:0] eidx;
  logic [PassW-1:0] pass_counter;
  logic [PassW-1:0] nodes;
  logic phase_reach;          // 1 reachability, 0 relaxation
  logic [NodeW:0] sweep;
  logic signed [ScoreW-1:0] res_score;
  logic [1:0] res_status;
  logic unbounded;            // final-pass relaxation out of a node that reaches the target

  // edge store
  logic ed_we;
  logic [EdgeW-1:0] ed_raddr;
  edge_rec_t ed_wdata, ed_rdata;
  // node memory, two copies so tail and head are read in the same cycle
  logic d_we;
  logic [NodeW-1:0] d_waddr, d_raddr_a, d_raddr_b;
  node_rec_t d_wdata, du_q, dv_q;

  assign nodes = (node_count > CfgW'(MaxNodes)) ? PassW'(MaxNodes) : PassW'(node_count);

  lpbf_ram #(.Width(EdgeRecW), .Depth(MaxEdges)) u_edges (
    .clk(clk), .we(ed_we), .waddr(edge_total[EdgeW-1:0]), .wdata(ed_wdata),
    .raddr(ed_raddr), .rdata(ed_rdata));

  lpbf_ram #(.Width(NodeRecW), .Depth(MaxNodes)) u_dist_a (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr_a), .rdata(du_q));
  lpbf_ram #(.Width(NodeRecW), .Depth(MaxNodes)) u_dist_b (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr_b), .rdata(dv_q));

  logic in_acc;
  logic can_issue;
  assign edge_in.ready = (state == S_LOAD);
  assign in_acc = edge_in.valid && edge_in.ready;
  assign ed_we = in_acc && (edge_total < CntW'(MaxEdges));
  assign ed_wdata = '{from: edge_in.edge_from, to: edge_in.edge_to,
                      weight: edge_in.edge_weight};
  assign ed_raddr = eidx[EdgeW-1:0];
  assign can_issue = !result.valid || result.ready;

  // held edge for the write-back stage
  edge_rec_t cur;
  logic cur_ok;
  // copy A reads the tail during passes and the target at the end
  assign d_raddr_a = (state == S_TGT || state == S_FINAL) ? target_node : ed_rdata.from;
  assign d_raddr_b = ed_rdata.to;

  // saturated candidate
  logic signed [ScoreW:0] sum_w;
  logic signed [ScoreW-1:0] cand;
  assign sum_w = {du_q.score[ScoreW-1], du_q.score}
               + {{(ScoreW+1-WeightW){cur.weight[WeightW-1]}}, cur.weight};
  always_comb begin
    if (sum_w[ScoreW] != sum_w[ScoreW-1])
      cand = sum_w[ScoreW] ? {1'b1, {(ScoreW-1){1'b0}}} : {1'b0, {(ScoreW-1){1'b1}}};
    else
      cand = sum_w[ScoreW-1:0];
  end

  logic relax, lastpass, reach_set;
  assign lastpass = (pass_counter == nodes);
  assign relax = cur_ok && du_q.valid && (!dv_q.valid || cand > dv_q.score);
  assign reach_set = cur_ok && dv_q.reach && !du_q.reach;

  // memory write source: sweep, reachability, relaxation
  always_comb begin
    d_we = 1'b0;
    d_waddr = '0;
    d_wdata = '0;
    case (state)
      S_CLEAR: begin
        d_we = 1'b1;
        d_waddr = sweep[NodeW-1:0];
        d_wdata.valid = (sweep[NodeW-1:0] == source_node);
        d_wdata.reach = (sweep[NodeW-1:0] == target_node);
      end
      S_WB: begin
        if (phase_reach) begin
          if (reach_set) begin
            d_we = 1'b1;
            d_waddr = cur.from;
            d_wdata = du_q;
            d_wdata.reach = 1'b1;
          end
        end else if (relax) begin
          d_we = 1'b1;
          d_waddr = cur.to;
          d_wdata = '{reach: dv_q.reach, valid: 1'b1, score: cand};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      node_count <= CfgW'(MaxNodes);
      source_node <= '0;
      target_node <= NodeW'(MaxNodes - 1);
      edge_total <= '0;
      result.valid <= 1'b0;
      eidx <= '0;
      pass_counter <= '0;
      phase_reach <= 1'b0;
      sweep <= '0;
      cur_ok <= 1'b0;
      unbounded <= 1'b0;
      res_score <= '0;
      res_status <= ST_FINITE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NODE_COUNT: node_count <= cfg_data;
          CFG_SOURCE: source_node <= cfg_data[NodeW-1:0];
          CFG_TARGET: target_node <= cfg_data[NodeW-1:0];
          default: ;
        endcase
      end
      // result register: loaded at the end of compute, cleared when taken
      if (state == S_FINAL && can_issue) result.valid <= 1'b1;
      else if (result.ready) result.valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (edge_total < CntW'(MaxEdges)) edge_total <= edge_total + 1'b1;
            if (edge_in.last_edge) begin
              sweep <= '0;
              state <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == (NodeW+1)'(MaxNodes - 1)) begin
            phase_reach <= 1'b1;
            pass_counter <= PassW'(1);
            eidx <= '0;
            unbounded <= 1'b0;
            if ({1'b0, source_node} >= nodes || {1'b0, target_node} >= nodes
                || edge_total == '0) state <= S_TGT;
            else state <= S_RD;
          end
        end
        S_RD: begin
          // edge read issued (ed_raddr = eidx)
          state <= S_DRD;
        end
        S_DRD: begin
          cur <= ed_rdata;
          cur_ok <= ({1'b0, ed_rdata.from} < nodes) && ({1'b0, ed_rdata.to} < nodes);
          state <= S_WB;
        end
        S_WB: begin
          if (!phase_reach && relax && lastpass && du_q.reach) unbounded <= 1'b1;
          if (eidx + 1'b1 == edge_total) begin
            eidx <= '0;
            if (lastpass) begin
              pass_counter <= PassW'(1);
              if (phase_reach) begin
                phase_reach <= 1'b0;
                state <= S_RD;
              end else begin
                state <= S_TGT;
              end
            end else begin
              pass_counter <= pass_counter + 1'b1;
              state <= S_RD;
            end
          end else begin
            eidx <= eidx + 1'b1;
            state <= S_RD;
          end
        end
        S_TGT: begin
          // target entry read issued
          state <= S_FINAL;
        end
        S_FINAL: begin
          if (can_issue) begin
            edge_total <= '0;
            res_score <= '0;
            if ({1'b0, source_node} >= nodes || {1'b0, target_node} >= nodes)
              res_status <= ST_UNREACH;
            else if (unbounded) res_status <= ST_UNBOUNDED;
            else if (!du_q.valid) res_status <= ST_UNREACH;
            else begin
              res_status <= ST_FINITE;
              res_score <= du_q.score;
            end
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign result.best_score = res_score;
  assign result.status = res_status;

  // a waiting result word holds steady
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> result.valid && $stable(result.best_score)
      && $stable(result.status));
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state));
  a_edge_cap: assert property (@(posedge clk) disable iff (rst)
    edge_total <= CntW'(MaxEdges));
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.status == ST_FINITE || result.status == ST_UNBOUNDED
      || result.status == ST_UNREACH));
  a_pass_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> pass_counter != '0 && pass_counter <= nodes);
endmodule
`default_nettype wire

>>> test/longest_path_bellman_ford_tb.sv
// Testbench for the longest-path block: directed graphs, then random graphs under back-pressure
`default_nettype none
module longest_path_bellman_ford_tb;
  import lpbf_pkg::*;

  localparam int WatchdogLimit = 100000;
  localparam int DrainCycles = 40;
  localparam longint ScoreTop = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ScoreBottom = -ScoreTop - 1;

  typedef struct {
    logic signed [ScoreW-1:0] score;
    logic [1:0] status;
  } path_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  lpbf_edge_if edge_ch ();
  lpbf_result_if res_ch ();

  // register copies and the graph being loaded
  int unsigned node_cnt = 256;
  int unsigned src_node = 0;
  int unsigned tgt_node = 255;
  edge_rec_t graph_edges[$];
  path_result_t expected_paths[$];

  int errors = 0;
  int graphs_sent = 0;
  int paths_checked = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;
  int ready_hold = 0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  longest_path_bellman_ford i_dut (
    .clk(clk),
    .rst(rst),
    .edge_in(edge_ch.sink),
    .result(res_ch.source),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint sat_score(longint v);
    if (v > ScoreTop) return ScoreTop;
    if (v < ScoreBottom) return ScoreBottom;
    return v;
  endfunction

  // best path weight from the source to the target over the loaded graph
  function automatic path_result_t best_path();
    path_result_t res;
    longint best[MaxNodes];
    bit reached[MaxNodes];
    bit on_cycle[MaxNodes];
    bit to_target[MaxNodes];
    int unsigned nodes;
    int unsigned u;
    int unsigned v;
    longint cand;
    bit unbounded;
    nodes = (node_cnt > MaxNodes) ? MaxNodes : node_cnt;
    res.score = '0;
    res.status = ST_UNREACH;
    if (src_node >= nodes || tgt_node >= nodes) return res;
    foreach (best[i]) begin
      best[i] = 0;
      reached[i] = 0;
      on_cycle[i] = 0;
      to_target[i] = 0;
    end
    reached[src_node] = 1;
    for (int p = 1; p <= nodes; p++) begin
      foreach (graph_edges[e]) begin
        u = graph_edges[e].from;
        v = graph_edges[e].to;
        if (u >= nodes || v >= nodes || !reached[u]) continue;
        cand = sat_score(best[u] + longint'(graph_edges[e].weight));
        if (!reached[v] || cand > best[v]) begin
          best[v] = cand;
          reached[v] = 1;
          if (p == nodes) on_cycle[u] = 1;
        end
      end
    end
    to_target[tgt_node] = 1;
    for (int p = 1; p <= nodes; p++) begin
      foreach (graph_edges[e]) begin
        u = graph_edges[e].from;
        v = graph_edges[e].to;
        if (u >= nodes || v >= nodes) continue;
        if (to_target[v]) to_target[u] = 1;
      end
    end
    unbounded = 0;
    for (int n = 0; n < nodes; n++)
      if (on_cycle[n] && to_target[n]) unbounded = 1;
    if (unbounded) begin
      res.status = ST_UNBOUNDED;
    end else if (reached[tgt_node]) begin
      res.status = ST_FINITE;
      res.score = best[tgt_node][ScoreW-1:0];
    end
    return res;
  endfunction

  // send one edge word and update the prediction once it is taken
  task automatic send_edge(input int unsigned from, input int unsigned to,
                           input logic signed [31:0] weight, input bit last);
    edge_rec_t rec;
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      edge_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    edge_ch.valid = 1'b1;
    edge_ch.edge_from = from[7:0];
    edge_ch.edge_to = to[7:0];
    edge_ch.edge_weight = weight;
    edge_ch.last_edge = last;
    do @(posedge clk); while (!edge_ch.ready);
    rec.from = from[7:0];
    rec.to = to[7:0];
    rec.weight = weight;
    if (graph_edges.size() < MaxEdges) graph_edges.insert(graph_edges.size(), rec);
    if (last) begin
      expected_paths.insert(expected_paths.size(), best_path());
      graph_edges.delete();
      graphs_sent++;
    end
  endtask

  task automatic go_idle();
    @(negedge clk);
    edge_ch.valid = 1'b0;
    edge_ch.last_edge = 1'b0;
    while (expected_paths.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[CfgW-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_NODE_COUNT: node_cnt = val & 9'h1FF;
      CFG_SOURCE: src_node = val & 8'hFF;
      CFG_TARGET: tgt_node = val & 8'hFF;
      default: ;
    endcase
  endtask

  task automatic set_graph(input int unsigned nodes, input int unsigned s, input int unsigned t);
    go_idle();
    write_reg(CFG_NODE_COUNT, nodes);
    write_reg(CFG_SOURCE, s);
    write_reg(CFG_TARGET, t);
  endtask

  // reset values: full node range, target at the top index
  task automatic test_reset_values();
    send_edge(0, 128, 32'sd9, 0);
    send_edge(128, 255, -32'sd4, 1);
  endtask

  // extremes of the fields and each special case
  task automatic test_directed();
    set_graph(4, 0, 3);
    send_edge(0, 1, 32'sh7FFF_FFFF, 0);
    send_edge(1, 3, 32'sh7FFF_FFFF, 0);
    send_edge(0, 3, 32'sh8000_0000, 1);
    // positive cycle that reaches the target
    send_edge(0, 1, 32'sd1, 0);
    send_edge(1, 2, 32'sd2, 0);
    send_edge(2, 1, 32'sd3, 0);
    send_edge(2, 3, -32'sd5, 1);
    // positive cycle off to the side, target still finite
    send_edge(0, 3, 32'sd7, 0);
    send_edge(0, 2, 32'sd1, 0);
    send_edge(2, 2, 32'sh7FFF_FFFF, 1);
    // target unreachable, endpoints outside the nodes in use
    send_edge(0, 1, 32'sd5, 0);
    send_edge(1, 200, 32'sd5, 0);
    send_edge(255, 3, 32'sd5, 1);
    // source and target beyond the nodes in use
    set_graph(4, 9, 3);
    send_edge(0, 3, 32'sd1, 1);
    set_graph(4, 0, 250);
    send_edge(0, 3, 32'sd1, 1);
    // no nodes at all
    set_graph(0, 0, 0);
    send_edge(0, 0, 32'sd1, 1);
    // node count above the maximum, negative cycle only
    set_graph(511, 255, 0);
    send_edge(255, 0, 32'sh8000_0000, 0);
    send_edge(0, 255, 32'sh8000_0000, 1);
    // single node, source equals target
    set_graph(1, 0, 0);
    send_edge(0, 0, -32'sd3, 1);
  endtask

  // more edges than the store holds; the flagged edge is dropped but still starts
  task automatic test_store_full();
    set_graph(3, 0, 2);
    calm = 1'b1;
    for (int i = 0; i < MaxEdges + 5; i++)
      send_edge($urandom_range(0, 3), $urandom_range(0, 3),
                $signed($urandom_range(0, 40)) - 32'sd30, i == MaxEdges + 4);
    calm = 1'b0;
  endtask

  // random graphs with random registers
  task automatic test_random_graphs();
    int sent;
    int unsigned nodes;
    int unsigned nedges;
    int unsigned s;
    int unsigned t;
    int r;
    logic signed [31:0] w;
    sent = 0;
    while (sent < 150) begin
      r = $urandom_range(0, 99);
      if (r < 80) nodes = $urandom_range(1, 12);
      else if (r < 90) nodes = 256;
      else if (r < 95) nodes = $urandom_range(257, 511);
      else if (r < 97) nodes = 0;
      else nodes = $urandom_range(13, 40);
      if (nodes > 0 && $urandom_range(0, 99) < 85) begin
        s = $urandom_range(0, (nodes > 256 ? 256 : nodes) - 1);
        t = $urandom_range(0, (nodes > 256 ? 256 : nodes) - 1);
      end else begin
        s = $urandom_range(0, 255);
        t = $urandom_range(0, 255);
      end
      set_graph(nodes, s, t);
      calm = ($urandom_range(0, 9) == 0);
      nedges = (nodes >= 256) ? $urandom_range(1, 8) : $urandom_range(1, 14);
      for (int e = 0; e < nedges; e++) begin
        r = $urandom_range(0, 99);
        if (r < 70) w = $signed($urandom_range(0, 60)) - 32'sd20;
        else if (r < 90) w = $urandom;
        else w = ($urandom_range(0, 1) != 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        if (nodes > 0 && $urandom_range(0, 99) < 90)
          send_edge($urandom_range(0, (nodes > 256 ? 256 : nodes) - 1),
                    $urandom_range(0, (nodes > 256 ? 256 : nodes) - 1), w, e == nedges - 1);
        else
          send_edge($urandom_range(0, 255), $urandom_range(0, 255), w, e == nedges - 1);
      end
      sent += nedges;
    end
    calm = 1'b0;
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      res_ch.ready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if (!calm) ready_hold <= pick_gap();
    end
  end

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    path_result_t exp_res;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_paths.size() == 0) begin
        $error("result word with no prediction: score %0d status %0d",
               res_ch.best_score, res_ch.status);
        errors++;
      end else begin
        exp_res = expected_paths.pop_front();
        paths_checked++;
        if (res_ch.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, res_ch.status);
          errors++;
        end
        if (res_ch.best_score !== exp_res.score) begin
          $error("best_score: expected %0d, got %0d", exp_res.score, res_ch.best_score);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (edge_ch.valid && edge_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_paths.size());
      $display("longest_path_bellman_ford_tb NOT OK");
      $finish;
    end
  end

  initial begin
    edge_ch.valid = 1'b0;
    edge_ch.edge_from = '0;
    edge_ch.edge_to = '0;
    edge_ch.edge_weight = '0;
    edge_ch.last_edge = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_values();
    test_directed();
    test_store_full();
    test_random_graphs();
    go_idle();
    repeat (DrainCycles) @(posedge clk);
    if (expected_paths.size() != 0) begin
      $error("%0d predicted results never arrived", expected_paths.size());
      errors++;
    end
    $display("covered %0d graphs, %0d results checked, %0d mismatches",
             graphs_sent, paths_checked, errors);
    if (errors == 0)
      $display("longest_path_bellman_ford_tb OK");
    else
      $display("longest_path_bellman_ford_tb NOT OK");
    $finish;
  end
endmodule
`default_nettype wire
